### rtl/assert_macros.svh
// Assertion macros used by the RTL of the peer key and MAC table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, held off while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check a property at each rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

### rtl/pkmt_pkg.sv
// Package for the peer key and MAC table: field widths, command codes,
// state codes, result layout and the key case-fold helper. No dependencies.
package pkmt_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_KEY_BYTES   = 8;

   localparam int CMD_W     = 3;
   localparam int NAME_W    = 64;
   localparam int MAC_W     = 48;
   localparam int OUT_IDX_W = 4;
   localparam int OUT_CNT_W = 5;
   localparam int MAXE_W    = 5;

   localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_END      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LEARN    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_KEY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND_MAC = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_RDLAST = 5'b00100,
      ST_MOVE   = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   // Result item, lowest bit first: ok, found, entry_index, mac_out,
   // mac_known, entry_count, zero pad.
   typedef struct packed {
      logic [3:0]           pad;
      logic [OUT_CNT_W-1:0] entry_count;
      logic                 mac_known;
      logic [MAC_W-1:0]     mac_out;
      logic [OUT_IDX_W-1:0] entry_index;
      logic                 found;
      logic                 ok;
   } rsp_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

### rtl/pkmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pkmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/peer_key_mac_table.sv
// Peer key and MAC table. An item scans the N live entries, one entry per cycle through the
// memory read port; a removal then passes through ST_RDLAST and ST_MOVE, and the result may
// wait in ST_RESP for the result register. One item is worked on at a time; the next is
// accepted only once the previous one has left ST_RESP, also while the previous result
// waits in the output register.
// Reset (synchronous) empties the table and sets the capacity to 16; memories are not
// cleared, as every live entry is written before it is read.
// Depends on pkmt_pkg, pkmt_ram and assert_macros.svh.
`include "assert_macros.svh"

module peer_key_mac_table #(
   parameter int TABLE_DEPTH = pkmt_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_BYTES   = pkmt_pkg::DEF_KEY_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // name_key[63:0], mac_in[111:64]
   input  logic [2:0]   req_tuser,   // command[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // ok, found, entry_index[5:2], mac_out[53:6],
                                     // mac_known[54], entry_count[59:55], zero
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data     // max_entries
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > pkmt_pkg::MAXE_W) ? CNT_W : pkmt_pkg::MAXE_W;
   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int MV_W  = pkmt_pkg::MAC_W + 1;

   pkmt_pkg::state_type state_ff, state_in;

   logic [pkmt_pkg::CMD_W-1:0]  cmd_ff;
   logic [KEY_W-1:0]            key_ff;
   logic [pkmt_pkg::MAC_W-1:0]  mac_ff;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic                        pend_ff, pend_in;
   logic [IDX_W-1:0]            pidx_ff, pidx_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic [pkmt_pkg::MAXE_W-1:0] max_ff;
   pkmt_pkg::rsp_type           res_ff, res_in;
   pkmt_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;

   logic [KEY_W-1:0]           key_norm;
   logic                       zero_seen;
   logic [KEY_W-1:0]           key_rd;
   logic [MV_W-1:0]            mac_rd;
   logic                       key_we, mac_we;
   logic [IDX_W-1:0]           wr_addr, rd_addr, last_idx;
   logic [KEY_W-1:0]           key_wdata;
   logic [MV_W-1:0]            mac_wdata;
   logic                       key_cmd, match, issue, full;
   logic [CMP_W-1:0]           cap;
   logic                       req_fire;
   logic                       upd_phase;
   logic                       resp_hold;

   assign req_tready = (state_ff == pkmt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      key_norm  = '0;
      zero_seen = 1'b0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (req_tdata[8*b +: 8] == 8'h00) begin
            zero_seen = 1'b1;
         end
         if (!zero_seen) begin
            key_norm[8*b +: 8] = pkmt_pkg::fold_char(req_tdata[8*b +: 8]);
         end
      end
   end

   assign key_cmd  = (cmd_ff == pkmt_pkg::CMD_START) || (cmd_ff == pkmt_pkg::CMD_END) ||
                     (cmd_ff == pkmt_pkg::CMD_FIND_KEY);
   assign match    = pend_ff && (key_cmd ? (key_rd == key_ff)
                     : (mac_rd[pkmt_pkg::MAC_W] && (mac_rd[pkmt_pkg::MAC_W-1:0] == mac_ff)));
   assign issue    = scan_ff < used_ff;
   assign cap      = (CMP_W'(max_ff) < CMP_W'(TABLE_DEPTH)) ? CMP_W'(max_ff)
                     : CMP_W'(TABLE_DEPTH);
   assign full     = CMP_W'(used_ff) >= cap;
   assign last_idx = IDX_W'(used_ff - CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      hit_idx_in    = hit_idx_ff;
      used_in       = used_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      key_we        = 1'b0;
      mac_we        = 1'b0;
      wr_addr       = pidx_ff;
      key_wdata     = key_ff;
      mac_wdata     = {1'b1, mac_ff};
      rd_addr       = scan_ff[IDX_W-1:0];
      case (state_ff)
         pkmt_pkg::ST_IDLE: begin
            if (req_fire) begin
               scan_in   = '0;
               res_in    = '0;
               res_in.ok = 1'b1;
               if (req_tuser inside {pkmt_pkg::CMD_START, pkmt_pkg::CMD_END,
                                     pkmt_pkg::CMD_LEARN, pkmt_pkg::CMD_FIND_KEY,
                                     pkmt_pkg::CMD_FIND_MAC}) begin
                  state_in = pkmt_pkg::ST_SCAN;
               end else begin
                  state_in = pkmt_pkg::ST_RESP;
               end
            end
         end
         pkmt_pkg::ST_SCAN: begin
            if (match) begin
               res_in.found       = 1'b1;
               res_in.entry_index = pkmt_pkg::OUT_IDX_W'(pidx_ff);
               res_in.mac_out     = mac_rd[pkmt_pkg::MAC_W-1:0];
               res_in.mac_known   = mac_rd[pkmt_pkg::MAC_W];
               hit_idx_in         = pidx_ff;
               state_in           = pkmt_pkg::ST_RESP;
               case (cmd_ff)
                  pkmt_pkg::CMD_END: begin
                     state_in = pkmt_pkg::ST_RDLAST;
                  end
                  pkmt_pkg::CMD_LEARN: begin
                     mac_we           = 1'b1;
                     res_in.mac_out   = mac_ff;
                     res_in.mac_known = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
               pend_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
            end else begin
               state_in = pkmt_pkg::ST_RESP;
               case (cmd_ff)
                  pkmt_pkg::CMD_START: begin
                     if (full) begin
                        res_in.ok = 1'b0;
                     end else begin
                        key_we             = 1'b1;
                        mac_we             = 1'b1;
                        wr_addr            = used_ff[IDX_W-1:0];
                        mac_wdata          = '0;
                        res_in.entry_index = pkmt_pkg::OUT_IDX_W'(used_ff[IDX_W-1:0]);
                        used_in            = used_ff + CNT_W'(1);
                     end
                  end
                  pkmt_pkg::CMD_LEARN: begin
                     if (used_ff != '0) begin
                        mac_we             = 1'b1;
                        wr_addr            = last_idx;
                        res_in.entry_index = pkmt_pkg::OUT_IDX_W'(last_idx);
                        res_in.mac_out     = mac_ff;
                        res_in.mac_known   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pkmt_pkg::ST_RDLAST: begin
            rd_addr  = last_idx;
            state_in = pkmt_pkg::ST_MOVE;
         end
         pkmt_pkg::ST_MOVE: begin
            key_we    = 1'b1;
            mac_we    = 1'b1;
            wr_addr   = hit_idx_ff;
            key_wdata = key_rd;
            mac_wdata = mac_rd;
            used_in   = used_ff - CNT_W'(1);
            state_in  = pkmt_pkg::ST_RESP;
         end
         pkmt_pkg::ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_in             = res_ff;
               rsp_in.entry_count = pkmt_pkg::OUT_CNT_W'(used_ff);
               rsp_tvalid_in      = 1'b1;
               state_in           = pkmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pkmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pkmt_pkg::ST_IDLE;
         pend_ff       <= 1'b0;
         used_ff       <= '0;
         max_ff        <= pkmt_pkg::MAXE_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         used_ff       <= used_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_tuser;
         key_ff <= key_norm;
         mac_ff <= req_tdata[111:64];
      end
      scan_ff    <= scan_in;
      pidx_ff    <= pidx_in;
      hit_idx_ff <= hit_idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   pkmt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   pkmt_ram #(
      .WIDTH (MV_W),
      .DEPTH (TABLE_DEPTH)
   ) u_mac_ram (
      .clock   (clock),
      .wr_en   (mac_we),
      .wr_addr (wr_addr),
      .wr_data (mac_wdata),
      .rd_addr (rd_addr),
      .rd_data (mac_rd)
   );

   assign upd_phase = (state_ff == pkmt_pkg::ST_SCAN) || (state_ff == pkmt_pkg::ST_MOVE);
   assign resp_hold = (state_ff == pkmt_pkg::ST_RESP) && rsp_tvalid_ff && !rsp_tready;

   `ASSERT_ALWAYS(a_used_bound, clock, reset || (used_ff <= CNT_W'(TABLE_DEPTH)))
   `ASSERT_CLKD(a_used_hold, clock, reset, !upd_phase |=> $stable(used_ff))
   `ASSERT_CLKD(a_write_phase, clock, reset, (key_we || mac_we) |-> upd_phase)
   `ASSERT_CLKD(a_resp_wait, clock, reset, resp_hold |=> (state_ff == pkmt_pkg::ST_RESP))

endmodule

### sim/peer_table_checker.sv
// Checker for the peer key and MAC table: watches the request, response and csr
// channels, predicts each response from its own copy of the table and compares.
// Depends on pkmt_pkg.
module peer_table_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,   // name_key[63:0], mac_in[111:64]
   input  logic [2:0]   req_tuser,   // command[2:0]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,   // ok, found, entry_index, mac_out, mac_known,
                                     // entry_count, zero
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [4:0]   csr_data,    // max_entries
   output int           errors,
   output int           pending
);
   import pkmt_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;

   logic [NAME_W-1:0] key_tab [DEPTH];
   logic [MAC_W-1:0]  mac_tab [DEPTH];
   logic              known_tab [DEPTH];
   int                used;
   int                cap;
   rsp_type           awaited_rsp [$];

   initial begin
      errors = 0;
      pending = 0;
   end

   function automatic logic [NAME_W-1:0] fold_key(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] k;
      logic [7:0]        c;
      k = '0;
      for (int b = 0; b < DEF_KEY_BYTES && b < 8; b++) begin
         c = raw[8*b +: 8];
         if (c == 8'h00) break;
         if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
         k[8*b +: 8] = c;
      end
      return k;
   endfunction

   function automatic int key_slot(input logic [NAME_W-1:0] k);
      for (int i = 0; i < used && i < DEPTH; i++) begin
         if (key_tab[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic int mac_slot(input logic [MAC_W-1:0] m);
      for (int i = 0; i < used && i < DEPTH; i++) begin
         if (known_tab[i] && mac_tab[i] == m) return i;
      end
      return -1;
   endfunction

   task automatic table_op(input logic [CMD_W-1:0] cmd, input logic [NAME_W-1:0] raw_key,
                           input logic [MAC_W-1:0] mac, output rsp_type r);
      logic [NAME_W-1:0] k;
      int                hit;
      int                last;
      k = fold_key(raw_key);
      r = '0;
      r.ok = 1'b1;
      case (cmd)
         CMD_START: begin
            hit = key_slot(k);
            if (hit >= 0) begin
               r.found = 1'b1;
               r.entry_index = 4'(hit);
               r.mac_out = mac_tab[hit];
               r.mac_known = known_tab[hit];
            end else if (used >= cap) begin
               r.ok = 1'b0;
            end else begin
               r.entry_index = 4'(used);
               key_tab[used] = k;
               mac_tab[used] = '0;
               known_tab[used] = 1'b0;
               used++;
            end
         end
         CMD_END: begin
            hit = key_slot(k);
            if (hit >= 0) begin
               last = used - 1;
               r.found = 1'b1;
               r.entry_index = 4'(hit);
               r.mac_out = mac_tab[hit];
               r.mac_known = known_tab[hit];
               key_tab[hit] = key_tab[last];
               mac_tab[hit] = mac_tab[last];
               known_tab[hit] = known_tab[last];
               used = last;
            end
         end
         CMD_LEARN: begin
            hit = mac_slot(mac);
            if (hit >= 0) r.found = 1'b1;
            else if (used > 0) hit = used - 1;
            if (hit >= 0) begin
               r.entry_index = 4'(hit);
               mac_tab[hit] = mac;
               known_tab[hit] = 1'b1;
               r.mac_out = mac;
               r.mac_known = 1'b1;
            end
         end
         CMD_FIND_KEY, CMD_FIND_MAC: begin
            hit = (cmd == CMD_FIND_KEY) ? key_slot(k) : mac_slot(mac);
            if (hit >= 0) begin
               r.found = 1'b1;
               r.entry_index = 4'(hit);
               r.mac_out = mac_tab[hit];
               r.mac_known = known_tab[hit];
            end
         end
         default: begin
         end
      endcase
      r.entry_count = 5'(used);
   endtask

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type seen;
      rsp_type due;
      if (reset) begin
         used = 0;
         cap = 16;
         for (int i = 0; i < DEPTH; i++) known_tab[i] = 1'b0;
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) cap = (csr_data > DEPTH) ? DEPTH : int'(csr_data);
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (awaited_rsp.size() == 0) begin
               $error("response item with nothing awaited: 0x%0h", rsp_tdata);
               errors++;
            end else begin
               due = awaited_rsp.pop_front();
               check_field("ok", due.ok, seen.ok);
               check_field("found", due.found, seen.found);
               check_field("entry_index", due.entry_index, seen.entry_index);
               check_field("mac_out", due.mac_out, seen.mac_out);
               check_field("mac_known", due.mac_known, seen.mac_known);
               check_field("entry_count", due.entry_count, seen.entry_count);
               check_field("pad", due.pad, seen.pad);
            end
         end
         if (req_tvalid && req_tready) begin
            table_op(req_tuser, req_tdata[63:0], req_tdata[111:64], due);
            awaited_rsp.push_back(due);
         end
      end
      pending <= awaited_rsp.size();
   end

endmodule

### sim/tb_peer_key_mac_table.sv
// Testbench top for the peer key and MAC table: clock, reset, request and csr
// stimulus, response back-pressure, watchdog and verdict.
// Depends on pkmt_pkg, peer_key_mac_table and peer_table_checker.
module tb_peer_key_mac_table;
   import pkmt_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 32;

   localparam logic [63:0] KEY_ALICE_LO = 64'h0000_0065_6369_6C61;
   localparam logic [63:0] KEY_ALICE_UP = 64'h0000_0045_4349_4C41;
   localparam logic [63:0] KEY_ALICE_MX = 64'h0000_0065_6369_6C41;
   localparam logic [63:0] KEY_BOB_JUNK = 64'hC3A5_5A00_0062_6F62;
   localparam logic [63:0] KEY_BOB_UP   = 64'h0000_0000_0042_4F42;
   localparam logic [63:0] KEY_BOB_LO   = 64'h0000_0000_0062_6F62;
   localparam logic [63:0] KEY_EDGES    = 64'h7B7A_6160_5B5A_4140;
   localparam logic [63:0] KEY_ONES     = '1;
   localparam logic [47:0] MAC_A        = 48'h02_1A_2B_3C_4D_5E;
   localparam logic [47:0] MAC_ONES     = '1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = '0;

   int           errors;
   int           pending;
   int           stall;
   bit           quiet = 1'b0;
   int           cmd_count [8];
   int           cap_writes = 0;
   logic [63:0]  name_pool [12];
   logic [47:0]  mac_pool [8];

   peer_key_mac_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   peer_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 23);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall = 0;
      end else begin
         stall++;
      end
      if (stall >= STALL_LIMIT) begin
         $display("tb_peer_key_mac_table: errors");
         $finish;
      end
   end

   function automatic logic [63:0] make_name();
      logic [63:0] n;
      int          len;
      n = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) begin
         if ($urandom_range(0, 9) == 0) n[8*b +: 8] = 8'($urandom_range(8'h01, 8'hFF));
         else n[8*b +: 8] = 8'($urandom_range(8'h61, 8'h7A));
      end
      return n;
   endfunction

   function automatic logic [63:0] vary_name(input logic [63:0] base);
      logic [63:0] r;
      logic [7:0]  c;
      bit          ended;
      r = base;
      ended = 1'b0;
      for (int b = 0; b < 8; b++) begin
         c = base[8*b +: 8];
         if (ended) begin
            if ($urandom_range(0, 1)) r[8*b +: 8] = 8'($urandom);
         end else if (c == 8'h00) begin
            ended = 1'b1;
         end else if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1)) begin
            r[8*b +: 8] = c - 8'h20;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return vary_name(name_pool[$urandom_range(0, 11)]);
      if (roll < 95) return {$urandom, $urandom};
      return roll[0] ? KEY_ONES : '0;
   endfunction

   function automatic logic [47:0] pick_mac();
      if ($urandom_range(0, 99) < 80) return mac_pool[$urandom_range(0, 7)];
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [2:0] pick_cmd();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return CMD_START;
      if (roll < 50) return CMD_END;
      if (roll < 70) return CMD_LEARN;
      if (roll < 82) return CMD_FIND_KEY;
      if (roll < 94) return CMD_FIND_MAC;
      return 3'(CMD_FIND_MAC + $urandom_range(1, 3));
   endfunction

   task automatic push_req(input logic [2:0] cmd, input logic [63:0] key,
                           input logic [47:0] mac);
      while (!quiet && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {mac, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cmd_count[cmd]++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_capacity(input int v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= 5'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cap_writes++;
   endtask

   task automatic run_random(input int n, input int quiet_items);
      for (int i = 0; i < n; i++) begin
         quiet = (i < quiet_items);
         push_req(pick_cmd(), pick_key(), pick_mac());
      end
      quiet = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 12; i++) name_pool[i] = make_name();
      for (int i = 0; i < 6; i++) mac_pool[i] = {16'($urandom), $urandom};
      mac_pool[6] = '0;
      mac_pool[7] = MAC_ONES;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_capacity(2);
      push_req(CMD_LEARN, KEY_ALICE_LO, MAC_A);
      push_req(CMD_END, KEY_ALICE_LO, '0);
      push_req(CMD_FIND_KEY, '0, '0);
      push_req(CMD_FIND_MAC, KEY_ONES, MAC_ONES);
      push_req(CMD_START, KEY_ALICE_UP, '0);
      push_req(CMD_START, KEY_ALICE_LO, '0);
      push_req(CMD_START, KEY_BOB_JUNK, '0);
      push_req(CMD_START, KEY_EDGES, '0);
      push_req(CMD_LEARN, '0, MAC_A);
      push_req(CMD_LEARN, KEY_ONES, MAC_A);
      push_req(CMD_FIND_MAC, '0, MAC_A);
      push_req(CMD_FIND_KEY, KEY_BOB_UP, '0);
      push_req(CMD_END, KEY_ALICE_MX, '0);
      push_req(CMD_FIND_KEY, KEY_BOB_LO, '0);
      push_req(CMD_START, KEY_EDGES, '0);
      push_req(CMD_LEARN, '0, '0);
      push_req(CMD_LEARN, '0, MAC_ONES);
      push_req(CMD_FIND_MAC, '0, '0);
      push_req(CMD_START, KEY_ONES, MAC_ONES);
      push_req(3'(CMD_FIND_MAC + 1), KEY_ONES, MAC_ONES);
      push_req(3'(CMD_FIND_MAC + 3), KEY_ONES, MAC_ONES);
      push_req(CMD_END, KEY_BOB_UP, '0);
      push_req(CMD_END, KEY_EDGES, '0);
      push_req(CMD_START, '0, '0);
      push_req(CMD_FIND_KEY, '0, '0);

      set_capacity(16);
      run_random(130, 0);
      set_capacity(1);
      run_random(40, 0);
      set_capacity(5);
      run_random(50, 0);
      set_capacity(16);
      run_random(120, 80);
      set_capacity($urandom_range(1, 16));
      run_random(30, 0);
      set_capacity(16);
      run_random(30, 0);

      drain();
      $display("covered %0d capacity settings, %0d start, %0d end, %0d learn items",
               cap_writes, cmd_count[CMD_START], cmd_count[CMD_END], cmd_count[CMD_LEARN]);
      $display("plus %0d find-by-key, %0d find-by-mac and %0d undefined-command items",
               cmd_count[CMD_FIND_KEY], cmd_count[CMD_FIND_MAC],
               cmd_count[5] + cmd_count[6] + cmd_count[7]);
      if (errors == 0) begin
         $display("tb_peer_key_mac_table: clean");
      end else begin
         $display("tb_peer_key_mac_table: errors");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/pkmt_pkg.sv
rtl/pkmt_ram.sv
rtl/peer_key_mac_table.sv
sim/peer_table_checker.sv
sim/tb_peer_key_mac_table.sv
